/* rtl/core/vna_pkg.sv */
package vna_pkg;

	localparam int POS_W  = 24;
	localparam int SUM_W  = 64;
	localparam int FACE_W = 51;
	localparam int NRM_W  = 16;
	localparam int IDX_W  = 16;
	localparam int VI_W   = 10;
	localparam int CNT_W  = 11;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_TRI   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct packed {
		logic signed [POS_W-1:0] z;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] x;
	} pos_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] z;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] x;
	} sum_t;

	typedef struct packed {
		logic signed [FACE_W-1:0] z;
		logic signed [FACE_W-1:0] y;
		logic signed [FACE_W-1:0] x;
	} face_t;

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] c2;
		logic [IDX_W-1:0] c1;
		logic [IDX_W-1:0] c0;
	} geom_ctrl_t;

	typedef struct packed {
		logic                    zero_sum;
		logic signed [NRM_W-1:0] z;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] x;
	} norm_res_t;

endpackage

/* rtl/core/vna_geom.sv */
module vna_geom #(
	parameter int MAX_VERTICES = 1024,
	localparam int IW = $clog2(MAX_VERTICES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vna_pkg::geom_ctrl_t ctrl,
	input  logic                wr_en,
	input  logic [IW-1:0]       wr_addr,
	input  vna_pkg::pos_t       wr_pos,
	output logic                done,
	output vna_pkg::face_t      face
);
	import vna_pkg::*;

	localparam logic [2:0] G_IDLE = 3'd0;
	localparam logic [2:0] G_RD1  = 3'd1;
	localparam logic [2:0] G_RD2  = 3'd2;
	localparam logic [2:0] G_RD3  = 3'd3;
	localparam logic [2:0] G_MUL  = 3'd4;

	pos_t mem [MAX_VERTICES];
	pos_t rd_q;
	pos_t p0_q;
	logic [IW-1:0] rd_addr;

	logic [2:0] state_q;
	logic [2:0] cnt_q;
	logic [2:0] prv;
	logic signed [POS_W:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [POS_W:0] opa, opb;
	logic signed [2*POS_W+1:0] prod_q;
	logic signed [FACE_W-1:0] prod_ext;
	logic signed [FACE_W-1:0] term;
	face_t face_q;
	logic  done_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_pos;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		rd_addr = ctrl.c0[IW-1:0];
		unique case (state_q)
			G_RD1:   rd_addr = ctrl.c1[IW-1:0];
			G_RD2:   rd_addr = ctrl.c2[IW-1:0];
			default: rd_addr = ctrl.c0[IW-1:0];
		endcase
	end

	always_comb begin
		case (cnt_q)
			3'd0:    begin opa = ay_q; opb = bz_q; end
			3'd1:    begin opa = az_q; opb = by_q; end
			3'd2:    begin opa = az_q; opb = bx_q; end
			3'd3:    begin opa = ax_q; opb = bz_q; end
			3'd4:    begin opa = ax_q; opb = by_q; end
			3'd5:    begin opa = ay_q; opb = bx_q; end
			default: begin opa = ax_q; opb = bx_q; end
		endcase
	end

	assign prv      = cnt_q - 3'd1;
	assign prod_ext = FACE_W'(prod_q);
	// odd products are the subtracted halves of each cross term
	assign term     = prv[0] ? -prod_ext : prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				G_IDLE: begin
					if (ctrl.start) state_q <= G_RD1;
				end
				G_RD1: state_q <= G_RD2;
				G_RD2: state_q <= G_RD3;
				G_RD3: begin
					cnt_q   <= '0;
					state_q <= G_MUL;
				end
				G_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_RD1: p0_q <= rd_q;
			G_RD2: begin
				ax_q <= (POS_W+1)'(rd_q.x) - (POS_W+1)'(p0_q.x);
				ay_q <= (POS_W+1)'(rd_q.y) - (POS_W+1)'(p0_q.y);
				az_q <= (POS_W+1)'(rd_q.z) - (POS_W+1)'(p0_q.z);
			end
			G_RD3: begin
				bx_q   <= (POS_W+1)'(rd_q.x) - (POS_W+1)'(p0_q.x);
				by_q   <= (POS_W+1)'(rd_q.y) - (POS_W+1)'(p0_q.y);
				bz_q   <= (POS_W+1)'(rd_q.z) - (POS_W+1)'(p0_q.z);
				face_q <= '0;
			end
			G_MUL: begin
				prod_q <= opa * opb;
				if (cnt_q != 3'd0) begin
					case (prv[2:1])
						2'd0:    face_q.x <= face_q.x + term;
						2'd1:    face_q.y <= face_q.y + term;
						default: face_q.z <= face_q.z + term;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign face = face_q;

endmodule

/* rtl/core/vna_norm.sv */
module vna_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  vna_pkg::sum_t      sum,
	output logic               done,
	output vna_pkg::norm_res_t res
);
	import vna_pkg::*;

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SQRT  = 3'd3;
	localparam logic [2:0] N_DINIT = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic [SUM_W-1:0] mag_q [3];
	logic [2:0] neg_q;
	logic [59:0] prod_q;
	logic [63:0] n_q, root_q, bit_q;
	logic [31:0] len_q;
	logic [47:0] rem_q;
	logic [48:0] dsh_q;
	logic [16:0] quo_q;
	norm_res_t res_q;
	logic done_q;

	logic [SUM_W-1:0] mx, my, mz, mor;
	logic [63:0] trial, root_nx;
	logic        take;
	logic        dtake;
	logic [16:0] quo_nx;
	logic [NRM_W-1:0] comp_val;

	assign mx  = sum.x[SUM_W-1] ? SUM_W'(-sum.x) : SUM_W'(sum.x);
	assign my  = sum.y[SUM_W-1] ? SUM_W'(-sum.y) : SUM_W'(sum.y);
	assign mz  = sum.z[SUM_W-1] ? SUM_W'(-sum.z) : SUM_W'(sum.z);
	assign mor = mag_q[0] | mag_q[1] | mag_q[2];

	assign trial   = root_q + bit_q;
	assign take    = n_q >= trial;
	assign root_nx = take ? ((root_q >> 1) + bit_q) : (root_q >> 1);

	assign dtake  = {1'b0, rem_q} >= dsh_q;
	assign quo_nx = {quo_q[15:0], dtake};

	always_comb begin
		if (neg_q[comp_q]) begin
			comp_val = quo_nx > 17'd32768 ? 16'h8000 : 16'((~quo_nx) + 17'd1);
		end else begin
			comp_val = quo_nx > 17'd32767 ? 16'h7FFF : quo_nx[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						if ((mx | my | mz) == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					if (mor[SUM_W-1:30] == '0) begin
						cnt_q   <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						cnt_q   <= '0;
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						cnt_q   <= '0;
						comp_q  <= '0;
						state_q <= N_DINIT;
					end
				end
				N_DINIT: state_q <= N_DIV;
				N_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						cnt_q  <= '0;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							state_q <= N_DINIT;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				// hold the last result until the next start
				if (start) begin
					mag_q[0] <= mx;
					mag_q[1] <= my;
					mag_q[2] <= mz;
					neg_q    <= {sum.z[SUM_W-1], sum.y[SUM_W-1], sum.x[SUM_W-1]};
					res_q    <= '{zero_sum: 1'b1, default: '0};
					n_q      <= '0;
				end
			end
			N_SHIFT: begin
				if (mor[SUM_W-1:30] != '0) begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end
			end
			N_SQ: begin
				// square one component while the previous square is summed
				if (cnt_q != 5'd3) begin
					prod_q <= mag_q[cnt_q[1:0]][29:0] * mag_q[cnt_q[1:0]][29:0];
				end
				if (cnt_q != 5'd0) begin
					n_q <= n_q + 64'(prod_q);
				end
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
			end
			N_SQRT: begin
				if (take) n_q <= n_q - trial;
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				if (cnt_q == 5'd31) len_q <= root_nx[31:0];
			end
			N_DINIT: begin
				rem_q <= {2'b00, mag_q[comp_q][29:0], 16'b0} + 48'(len_q);
				dsh_q <= {len_q, 17'b0};
				quo_q <= '0;
			end
			N_DIV: begin
				if (dtake) rem_q <= rem_q - dsh_q[47:0];
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nx;
				if (cnt_q == 5'd16) begin
					res_q.zero_sum <= 1'b0;
					case (comp_q)
						2'd0:    res_q.x <= comp_val;
						2'd1:    res_q.y <= comp_val;
						default: res_q.z <= comp_val;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/core/vertex_normal_accumulator_unit.sv */
// Area-weighted vertex normal accumulator. op 0 stores a Q12.12 position
// and clears that vertex's normal sum; op 1 reads the three corner
// positions from the position memory, forms the face normal with one
// shared multiplier over six steps and then does a read-modify-write of
// each corner's 64-bit saturating sum; op 2 reads one sum and normalizes
// it to Q1.15 through a bit-serial square root and a shared restoring
// divider, after a right shift of 0..34 bits that brings the largest
// magnitude under 2^30. A result waits in the output register while the
// next item is taken.
module vertex_normal_accumulator_unit #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vert_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, zero pad
	input  logic [135:0] s_tdata,
	// op
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, normal_z
	output logic [47:0]  m_tdata,
	// zero_sum
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [10:0]  cfg_data
);
	import vna_pkg::*;

	localparam int IW = $clog2(MAX_VERTICES);

	localparam logic [2:0] T_IDLE   = 3'd0;
	localparam logic [2:0] T_GEOM   = 3'd1;
	localparam logic [2:0] T_RMW_RD = 3'd2;
	localparam logic [2:0] T_RMW_WR = 3'd3;
	localparam logic [2:0] T_NRD    = 3'd4;
	localparam logic [2:0] T_NORM   = 3'd5;
	localparam logic [2:0] T_PUSH   = 3'd6;

	logic [2:0] state_q;
	logic [CNT_W-1:0] vcount_q;
	logic [IDX_W-1:0] corner_q [3];
	logic [1:0] k_q;
	logic start_q;
	logic rd_ok_q;
	logic m_valid_q;
	norm_res_t out_q;
	face_t face_q;

	logic [VI_W-1:0] vert_index;
	pos_t in_pos;
	logic [IDX_W-1:0] ca, cb, cc;
	logic accept;
	logic vi_ok, tri_ok;

	sum_t sum_mem [MAX_VERTICES];
	sum_t sum_rd_q;
	logic [IW-1:0] sum_raddr, sum_waddr;
	logic sum_we;
	sum_t sum_wdata, sum_new;

	geom_ctrl_t geom_ctrl;
	logic geom_done;
	face_t geom_face;
	logic norm_start, norm_done;
	sum_t norm_in;
	norm_res_t norm_res;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]  a,
		input logic signed [FACE_W-1:0] b
	);
		logic signed [SUM_W:0] r;
		r = (SUM_W+1)'(a) + (SUM_W+1)'(b);
		if (r[SUM_W] != r[SUM_W-1]) begin
			return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return r[SUM_W-1:0];
	endfunction

	assign vert_index = s_tdata[9:0];
	assign in_pos.x   = s_tdata[33:10];
	assign in_pos.y   = s_tdata[57:34];
	assign in_pos.z   = s_tdata[81:58];
	assign ca         = s_tdata[97:82];
	assign cb         = s_tdata[113:98];
	assign cc         = s_tdata[129:114];

	assign s_tready  = (state_q == T_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign vi_ok   = {7'b0, vert_index} < 17'(MAX_VERTICES);
	assign tri_ok  = ({1'b0, ca} < 17'(MAX_VERTICES)) && (ca < IDX_W'(vcount_q))
	              && ({1'b0, cb} < 17'(MAX_VERTICES)) && (cb < IDX_W'(vcount_q))
	              && ({1'b0, cc} < 17'(MAX_VERTICES)) && (cc < IDX_W'(vcount_q));

	logic [IDX_W-1:0] vi_ext;
	assign vi_ext = IDX_W'(vert_index);

	always_comb begin
		sum_raddr = vi_ext[IW-1:0];
		sum_waddr = vi_ext[IW-1:0];
		sum_wdata = '0;
		sum_we    = accept && (s_tuser == OP_WRITE) && vi_ok;
		if (state_q == T_RMW_RD || state_q == T_RMW_WR) begin
			sum_raddr = corner_q[k_q][IW-1:0];
			sum_waddr = corner_q[k_q][IW-1:0];
			sum_wdata = sum_new;
			sum_we    = (state_q == T_RMW_WR);
		end
	end

	assign sum_new.x = sat_add(sum_rd_q.x, face_q.x);
	assign sum_new.y = sat_add(sum_rd_q.y, face_q.y);
	assign sum_new.z = sat_add(sum_rd_q.z, face_q.z);

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		sum_rd_q <= sum_mem[sum_raddr];
	end

	assign geom_ctrl.start = start_q;
	assign geom_ctrl.c0    = corner_q[0];
	assign geom_ctrl.c1    = corner_q[1];
	assign geom_ctrl.c2    = corner_q[2];

	vna_geom #(.MAX_VERTICES(MAX_VERTICES)) u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (geom_ctrl),
		.wr_en   (accept && (s_tuser == OP_WRITE) && vi_ok),
		.wr_addr (vi_ext[IW-1:0]),
		.wr_pos  (in_pos),
		.done    (geom_done),
		.face    (geom_face)
	);

	assign norm_start = (state_q == T_NRD);
	assign norm_in    = rd_ok_q ? sum_rd_q : '0;

	vna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.sum    (norm_in),
		.done   (norm_done),
		.res    (norm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			vcount_q  <= '0;
			k_q       <= '0;
			start_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_valid) vcount_q <= cfg_data;
			if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						unique case (s_tuser)
							OP_WRITE: ;
							OP_TRI: begin
								if (tri_ok) begin
									start_q <= 1'b1;
									state_q <= T_GEOM;
								end
							end
							OP_READ: state_q <= T_NRD;
							OP_NONE: ;
						endcase
					end
				end
				T_GEOM: begin
					if (geom_done) begin
						k_q     <= '0;
						state_q <= T_RMW_RD;
					end
				end
				T_RMW_RD: state_q <= T_RMW_WR;
				T_RMW_WR: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? T_IDLE : T_RMW_RD;
				end
				T_NRD:  state_q <= T_NORM;
				T_NORM: begin
					if (norm_done) state_q <= T_PUSH;
				end
				T_PUSH: begin
					if (!m_valid_q) begin
						m_valid_q <= 1'b1;
						state_q   <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			corner_q[0] <= ca;
			corner_q[1] <= cb;
			corner_q[2] <= cc;
			rd_ok_q     <= vi_ok;
		end
		if (geom_done) face_q <= geom_face;
		if (state_q == T_PUSH && !m_valid_q) out_q <= norm_res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_q.z, out_q.y, out_q.x};
	assign m_tuser  = out_q.zero_sum;

endmodule
